>>> design/rpa_pkg.sv
// Shared constants, request and status codes, and controller/datapath link types.
package rpa_pkg;

  localparam int NUM_PAGES_DEF = 32768;

  localparam int REQ_W    = 2;
  localparam int PAGE_W   = 16;
  localparam int FIRST_W  = 15;
  localparam int STATUS_W = 3;
  localparam int GRANT_W  = 15;
  localparam int COUNT_W  = 16;

  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_INCR  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_SEED  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_PAGE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BELOW_ONE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;

  typedef struct packed {
    logic clr_we;
    logic load;
    logic exec;
  } rpa_cmd_t;

  typedef struct packed {
    logic clr_last;
  } rpa_sts_t;

endpackage

>>> design/rpa_ctrl.sv
// Controller: clearing pass, request accept and execute sequencing, output valid.
module rpa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  rpa_pkg::rpa_sts_t sts,
  output rpa_pkg::rpa_cmd_t cmd
);
  import rpa_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid_r || !out_stall) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> design/rpa_dp.sv
// Datapath: count and free-stack memories, stack pointer, request and result registers.
module rpa_dp #(
  parameter int NUM_PAGES = rpa_pkg::NUM_PAGES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [rpa_pkg::FIRST_W-1:0]    cfg_wr_data,
  input  logic [rpa_pkg::REQ_W-1:0]      in_req_type,
  input  logic [rpa_pkg::PAGE_W-1:0]     in_page,
  input  rpa_pkg::rpa_cmd_t              cmd,
  output rpa_pkg::rpa_sts_t              sts,
  output logic [rpa_pkg::STATUS_W-1:0]   out_status,
  output logic [rpa_pkg::GRANT_W-1:0]    out_granted_page,
  output logic                           out_page_freed,
  output logic [rpa_pkg::COUNT_W-1:0]    out_new_count
);
  import rpa_pkg::*;

  localparam int PW = $clog2(NUM_PAGES);
  localparam int TW = $clog2(NUM_PAGES + 1);
  localparam int SW = (PW > PAGE_W) ? PAGE_W : PW;

  logic [COUNT_W-1:0] cnt_mem [NUM_PAGES];
  logic [SW-1:0]      stk_mem [NUM_PAGES];

  logic [FIRST_W-1:0] first_page_r;
  logic [PW-1:0]      clr_cnt_r;
  logic [TW-1:0]      top_r, top_nxt;
  logic [REQ_W-1:0]   req_r;
  logic [PAGE_W-1:0]  page_r;
  logic               ok_r;
  logic [COUNT_W-1:0] cnt_q_r;
  logic [SW-1:0]      stk_q_r;

  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [GRANT_W-1:0]  granted_r, granted_nxt;
  logic                freed_r, freed_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;

  logic               in_ok;
  logic               cnt_re, stk_re;
  logic [PW-1:0]      cnt_raddr, stk_raddr;
  logic               ex_cnt_we, cnt_we, push, stk_we;
  logic [PW-1:0]      ex_cnt_waddr, cnt_waddr;
  logic [COUNT_W-1:0] ex_cnt_wdata, cnt_wdata;
  logic               stack_full;

  assign in_ok = (in_page >= {1'b0, first_page_r}) && (32'(in_page) < NUM_PAGES);
  assign cnt_re    = cmd.load && in_ok;
  assign cnt_raddr = PW'(in_page);
  assign stk_re    = cmd.load && (in_req_type == REQ_ALLOC) && (top_r != '0);
  assign stk_raddr = PW'(top_r - TW'(1));
  assign stack_full = (top_r == TW'(NUM_PAGES));

  assign sts.clr_last = (clr_cnt_r == PW'(NUM_PAGES - 1));

  always_comb begin
    status_nxt   = ST_OK;
    granted_nxt  = '0;
    freed_nxt    = 1'b0;
    count_nxt    = '0;
    ex_cnt_we    = 1'b0;
    ex_cnt_waddr = PW'(page_r);
    ex_cnt_wdata = '0;
    push         = 1'b0;
    top_nxt      = top_r;
    if (req_r == REQ_ALLOC) begin
      if (top_r == '0) begin
        status_nxt = ST_EMPTY;
      end else begin
        granted_nxt  = GRANT_W'(stk_q_r);
        count_nxt    = COUNT_W'(1);
        ex_cnt_we    = 1'b1;
        ex_cnt_waddr = PW'(stk_q_r);
        ex_cnt_wdata = COUNT_W'(1);
        top_nxt      = top_r - TW'(1);
      end
    end else if (!ok_r) begin
      status_nxt = ST_BAD_PAGE;
    end else begin
      case (req_r)
        REQ_FREE: begin
          if (cnt_q_r == '0) begin
            status_nxt = ST_BELOW_ONE;
          end else begin
            count_nxt    = cnt_q_r - COUNT_W'(1);
            ex_cnt_we    = 1'b1;
            ex_cnt_wdata = count_nxt;
            push         = (count_nxt == '0);
          end
        end
        REQ_INCR: begin
          if (cnt_q_r == '0) begin
            status_nxt = ST_BELOW_ONE;
          end else if (cnt_q_r == '1) begin
            status_nxt = ST_OVERFLOW;
            count_nxt  = cnt_q_r;
          end else begin
            count_nxt    = cnt_q_r + COUNT_W'(1);
            ex_cnt_we    = 1'b1;
            ex_cnt_wdata = count_nxt;
          end
        end
        default: begin
          ex_cnt_we    = 1'b1;
          ex_cnt_wdata = '0;
          push         = 1'b1;
        end
      endcase
      if (push && !stack_full) begin
        freed_nxt = 1'b1;
        top_nxt   = top_r + TW'(1);
      end
    end
  end

  assign stk_we    = cmd.exec && freed_nxt;
  assign cnt_we    = cmd.clr_we || (cmd.exec && ex_cnt_we);
  assign cnt_waddr = cmd.clr_we ? clr_cnt_r : ex_cnt_waddr;
  assign cnt_wdata = cmd.clr_we ? '0 : ex_cnt_wdata;

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_q_r <= cnt_mem[cnt_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[PW'(top_r)] <= SW'(page_r);
    end
    if (stk_re) begin
      stk_q_r <= stk_mem[stk_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_page_r <= '0;
      clr_cnt_r    <= '0;
      top_r        <= '0;
    end else begin
      if (cfg_wr_en) begin
        first_page_r <= cfg_wr_data;
      end
      if (cmd.clr_we) begin
        clr_cnt_r <= clr_cnt_r + PW'(1);
      end
      if (cmd.exec) begin
        top_r <= top_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_req_type;
      page_r <= in_page;
      ok_r   <= in_ok;
    end
    if (cmd.exec) begin
      status_r  <= status_nxt;
      granted_r <= granted_nxt;
      freed_r   <= freed_nxt;
      count_r   <= count_nxt;
    end
  end

  assign out_status       = status_r;
  assign out_granted_page = granted_r;
  assign out_page_freed   = freed_r;
  assign out_new_count    = count_r;

endmodule

>>> design/refcounted_page_allocator_top.sv
// Top level of the reference-counted page allocator with a LIFO free stack.
//
//   channel  direction  handshake             payload
//   cfg      in         cfg_wr_en             cfg_wr_data (first_page)
//   in       in         in_valid / in_stall   in_req_type, in_page
//   out      out        out_valid / out_stall out_status, out_granted_page,
//                                             out_page_freed, out_new_count
//
// The accept cycle reads the count or stack memory; the execute state then does the
// read-modify-write and loads the result register.
// After reset a clearing pass zeroes the count memory, with in_stall high throughout.
// The next item is taken while a result waits; a stalled result holds the execute cycle.
module refcounted_page_allocator_top #(
  parameter int NUM_PAGES = rpa_pkg::NUM_PAGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [rpa_pkg::FIRST_W-1:0]  cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [rpa_pkg::REQ_W-1:0]    in_req_type,
  input  logic [rpa_pkg::PAGE_W-1:0]   in_page,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rpa_pkg::STATUS_W-1:0] out_status,
  output logic [rpa_pkg::GRANT_W-1:0]  out_granted_page,
  output logic                         out_page_freed,
  output logic [rpa_pkg::COUNT_W-1:0]  out_new_count
);
  import rpa_pkg::*;

  rpa_cmd_t cmd;
  rpa_sts_t sts;

  rpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rpa_dp #(
    .NUM_PAGES (NUM_PAGES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_req_type      (in_req_type),
    .in_page          (in_page),
    .cmd              (cmd),
    .sts              (sts),
    .out_status       (out_status),
    .out_granted_page (out_granted_page),
    .out_page_freed   (out_page_freed),
    .out_new_count    (out_new_count)
  );

endmodule
